// File: src/nmit_pkg.sv
package nmit_pkg;

    // Width of the singular threshold register.
    localparam int THR_WIDTH = 32;

    // Per-result status carried alongside the nine entries.
    typedef struct packed {
        logic singular;
        logic saturated;
    } flags_t;

endpackage

// File: src/nmit_if.sv
interface nmit_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] col0_row0;
    logic signed [W-1:0] col0_row1;
    logic signed [W-1:0] col0_row2;
    logic signed [W-1:0] col1_row0;
    logic signed [W-1:0] col1_row1;
    logic signed [W-1:0] col1_row2;
    logic signed [W-1:0] col2_row0;
    logic signed [W-1:0] col2_row1;
    logic signed [W-1:0] col2_row2;

    modport source (
        output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
               col1_row2, col2_row0, col2_row1, col2_row2,
        input  ready
    );
    modport sink (
        input  valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
               col1_row2, col2_row0, col2_row1, col2_row2,
        output ready
    );
endinterface

interface nmit_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] res_col0_row0;
    logic signed [W-1:0] res_col0_row1;
    logic signed [W-1:0] res_col0_row2;
    logic signed [W-1:0] res_col1_row0;
    logic signed [W-1:0] res_col1_row1;
    logic signed [W-1:0] res_col1_row2;
    logic signed [W-1:0] res_col2_row0;
    logic signed [W-1:0] res_col2_row1;
    logic signed [W-1:0] res_col2_row2;
    logic                singular;
    logic                saturated;

    modport source (
        output valid, res_col0_row0, res_col0_row1, res_col0_row2, res_col1_row0,
               res_col1_row1, res_col1_row2, res_col2_row0, res_col2_row1,
               res_col2_row2, singular, saturated,
        input  ready
    );
    modport sink (
        input  valid, res_col0_row0, res_col0_row1, res_col0_row2, res_col1_row0,
               res_col1_row1, res_col1_row2, res_col2_row0, res_col2_row1,
               res_col2_row2, singular, saturated,
        output ready
    );
endinterface

// File: src/nmit_cofactor.sv
module nmit_cofactor #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] a [3][3],
    output logic                out_valid,
    output logic signed [2*W:0] cof [3][3],
    output logic signed [W-1:0] row0 [3]
);

    logic signed [2*W-1:0] pa_reg [3][3];
    logic signed [2*W-1:0] pb_reg [3][3];
    logic signed [2*W:0]   cof_reg [3][3];
    logic signed [W-1:0]   a0_reg [3];
    logic signed [W-1:0]   row0_reg [3];
    logic [1:0]            v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < 3; r++)
        begin : g_row
            for (c = 0; c < 3; c++)
            begin : g_col
                // Rows and columns left once row r and column c are struck out.
                localparam int R1 = (r == 0) ? 1 : 0;
                localparam int R2 = (r == 2) ? 1 : 2;
                localparam int C1 = (c == 0) ? 1 : 0;
                localparam int C2 = (c == 2) ? 1 : 2;
                localparam bit NEG = ((r + c) % 2) == 1;

                logic signed [2*W:0] diff;

                assign diff = {pa_reg[r][c][2*W-1], pa_reg[r][c]}
                            - {pb_reg[r][c][2*W-1], pb_reg[r][c]};

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        pa_reg[r][c]  <= a[R1][C1] * a[R2][C2];
                        pb_reg[r][c]  <= a[R1][C2] * a[R2][C1];
                        cof_reg[r][c] <= NEG ? -diff : diff;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg   <= a[0];
            row0_reg <= a0_reg;
        end
    end

    assign out_valid = v_reg[1];
    assign cof       = cof_reg;
    assign row0      = row0_reg;

endmodule

// File: src/nmit_det.sv
module nmit_det #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [2*W:0]               cof_in [3][3],
    input  logic signed [W-1:0]               row0 [3],
    input  logic [nmit_pkg::THR_WIDTH-1:0]    thr,
    output logic                              out_valid,
    output logic                              singular,
    output logic                              dneg,
    output logic [3*W+2:0]                    dmag,
    output logic signed [2*W:0]               cof_out [3][3]
);

    localparam int DW = 3 * W + 3;
    localparam int TW = nmit_pkg::THR_WIDTH + 2 * F;
    localparam int LW = (DW > TW) ? DW : TW;

    logic signed [2*W:0] lo_reg [3];
    logic signed [2*W:0] hi_reg [3];
    logic [DW-1:0]       t_reg [3];
    logic [DW-1:0]       t_next [3];
    logic [DW-1:0]       det_reg;
    logic [DW-1:0]       dmag_reg;
    logic [DW-1:0]       dmag_next;
    logic                dneg_reg;
    logic                sing_reg;
    logic [TW-1:0]       lim;
    logic signed [2*W:0] cp_reg [4][3][3];
    logic [3:0]          v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // Each product a0j * c0j is split at bit W of the cofactor.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            t_next[j] = ({{(DW-2*W-1){hi_reg[j][2*W]}}, hi_reg[j]} << W)
                      + {{(DW-2*W-1){lo_reg[j][2*W]}}, lo_reg[j]};
        end
    end

    assign dmag_next = det_reg[DW-1] ? -det_reg : det_reg;
    assign lim       = {thr, {(2*F){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= row0[j] * $signed({1'b0, cof_in[0][j][W-1:0]});
                hi_reg[j] <= row0[j] * $signed(cof_in[0][j][2*W:W]);
            end
            t_reg    <= t_next;
            det_reg  <= t_reg[0] + t_reg[1] + t_reg[2];
            dneg_reg <= det_reg[DW-1];
            dmag_reg <= dmag_next;
            sing_reg <= LW'(dmag_next) <= LW'(lim);
            cp_reg[0] <= cof_in;
            cp_reg[1] <= cp_reg[0];
            cp_reg[2] <= cp_reg[1];
            cp_reg[3] <= cp_reg[2];
        end
    end

    assign out_valid = v_reg[3];
    assign singular  = sing_reg;
    assign dneg      = dneg_reg;
    assign dmag      = dmag_reg;
    assign cof_out   = cp_reg[3];

endmodule

// File: src/nmit_divide.sv
module nmit_divide #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic                   singular,
    input  logic                   dneg,
    input  logic [3*W+2:0]         dmag,
    input  logic signed [2*W:0]    cof [3][3],
    output logic                   out_valid,
    output logic signed [W-1:0]    res [3][3],
    output nmit_pkg::flags_t       flags
);

    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NW = CW + 2 * F;
    localparam int DS = DW + W;
    localparam int RW = (NW > DS) ? NW : DS;
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAXNEG = {1'b1, {(W-1){1'b0}}};

    logic [RW-1:0] rem_reg [W+1][9];
    logic [W-1:0]  quo_reg [W+1][9];
    logic          ovf_reg [W+1][9];
    logic          neg_reg [W+1][9];
    logic [DW-1:0] dm_reg [W+1];
    logic          sng_reg [W+1];
    logic [W:0]    v_reg;

    logic [RW-1:0] rem_next [9];
    logic          ovf_next [9];
    logic          neg_next [9];

    logic signed [W-1:0] res_reg [3][3];
    logic signed [W-1:0] res_next [3][3];
    nmit_pkg::flags_t    flags_reg;
    nmit_pkg::flags_t    flags_next;
    logic                out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[W-1:0], in_valid};
            out_valid_reg <= v_reg[W];
        end
    end

    // Front stage: magnitudes, result sign and the overflow test against |det| * 2^W.
    always_comb
    begin
        logic          cneg;
        logic [CW-1:0] cmag;
        logic [NW-1:0] num;
        for (int k = 0; k < 9; k++)
        begin
            cneg        = cof[k % 3][k / 3][CW-1];
            cmag        = cneg ? -cof[k % 3][k / 3] : cof[k % 3][k / 3];
            num         = {cmag, {(2*F){1'b0}}};
            rem_next[k] = RW'(num);
            ovf_next[k] = RW'(num) >= (RW'(dmag) << W);
            neg_next[k] = cneg ^ dneg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                rem_reg[0][k] <= rem_next[k];
                quo_reg[0][k] <= '0;
                ovf_reg[0][k] <= ovf_next[k];
                neg_reg[0][k] <= neg_next[k];
            end
            dm_reg[0]  <= dmag;
            sng_reg[0] <= singular;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    genvar s;
    generate
        for (s = 1; s <= W; s++)
        begin : g_step
            localparam int BIT = W - s;

            logic [RW-1:0] trial;

            assign trial = RW'(dm_reg[s-1]) << BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int k = 0; k < 9; k++)
                    begin
                        if (rem_reg[s-1][k] >= trial)
                        begin
                            rem_reg[s][k] <= rem_reg[s-1][k] - trial;
                            quo_reg[s][k] <= quo_reg[s-1][k] | (W'(1) << BIT);
                        end
                        else
                        begin
                            rem_reg[s][k] <= rem_reg[s-1][k];
                            quo_reg[s][k] <= quo_reg[s-1][k];
                        end
                        ovf_reg[s][k] <= ovf_reg[s-1][k];
                        neg_reg[s][k] <= neg_reg[s-1][k];
                    end
                    dm_reg[s]  <= dm_reg[s-1];
                    sng_reg[s] <= sng_reg[s-1];
                end
            end
        end
    endgenerate

    // Sign, clamp and zero forcing for a singular matrix.
    always_comb
    begin
        logic         neg_eff;
        logic         sat_l;
        logic         sat_any;
        logic [W-1:0] q;
        logic [W-1:0] qs;
        sat_any = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            q       = quo_reg[W][k];
            neg_eff = neg_reg[W][k] & (ovf_reg[W][k] | (q != '0));
            sat_l   = ovf_reg[W][k] | (neg_eff ? (q > MAXNEG) : (q > MAXPOS));
            qs      = sat_l ? (neg_eff ? MAXNEG : MAXPOS) : q;
            res_next[k % 3][k / 3] = sng_reg[W] ? '0 : $signed(neg_eff ? -qs : qs);
            sat_any = sat_any | sat_l;
        end
        flags_next.singular  = sng_reg[W];
        flags_next.saturated = sat_any & ~sng_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= res_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign flags     = flags_reg;

endmodule

// File: src/normal_matrix_inverse_transpose_core.sv
// Normal-matrix unit: transpose of the inverse of a 3x3 fixed-point matrix.
// The input channel carries one transaction per matrix, nine signed entries
// in column-major order; the output channel carries the nine quotients
// cofactor(row,col)/det with the singular and saturated flags.
// The threshold register is loaded through cfg_we/cfg_data; the user must load it
// only while the unit is idle, as the block itself does not enforce this. A matrix
// whose determinant magnitude is at or below it gives zeros. From input
// transaction to output valid a matrix passes two cofactor stages, four
// determinant stages, one overflow stage, one stage per quotient bit of the
// nine parallel restoring dividers, and the output register.
// Throughput is one matrix per cycle while the receiver does not stall, all stages advancing together.
// When the receiver stalls with a result waiting, every stage holds and the
// input channel drops ready; nothing is lost or repeated.
// Reset clears all valid bits and the threshold; no results are pending.
module normal_matrix_inverse_transpose_core #(
    parameter int ENTRY_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    nmit_in_if.sink                        in_ch,
    nmit_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [nmit_pkg::THR_WIDTH-1:0] cfg_data
);

    localparam int W = ENTRY_WIDTH;

    logic [nmit_pkg::THR_WIDTH-1:0] thr_reg;
    logic                           en;
    logic signed [W-1:0]            a [3][3];
    logic                           cf_valid;
    logic signed [2*W:0]            cof [3][3];
    logic signed [W-1:0]            row0 [3];
    logic                           dt_valid;
    logic                           dt_singular;
    logic                           dt_neg;
    logic [3*W+2:0]                 dt_mag;
    logic signed [2*W:0]            dt_cof [3][3];
    logic                           res_valid;
    logic signed [W-1:0]            res [3][3];
    nmit_pkg::flags_t               flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // The whole pipeline moves whenever the output register is free or being emptied.
    assign en          = !res_valid || out_ch.ready;
    assign in_ch.ready = en;

    assign a[0][0] = in_ch.col0_row0;
    assign a[1][0] = in_ch.col0_row1;
    assign a[2][0] = in_ch.col0_row2;
    assign a[0][1] = in_ch.col1_row0;
    assign a[1][1] = in_ch.col1_row1;
    assign a[2][1] = in_ch.col1_row2;
    assign a[0][2] = in_ch.col2_row0;
    assign a[1][2] = in_ch.col2_row1;
    assign a[2][2] = in_ch.col2_row2;

    nmit_cofactor #(.W(W)) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .a         (a),
        .out_valid (cf_valid),
        .cof       (cof),
        .row0      (row0)
    );

    nmit_det #(.W(W), .F(FRAC_BITS)) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cf_valid),
        .cof_in    (cof),
        .row0      (row0),
        .thr       (thr_reg),
        .out_valid (dt_valid),
        .singular  (dt_singular),
        .dneg      (dt_neg),
        .dmag      (dt_mag),
        .cof_out   (dt_cof)
    );

    nmit_divide #(.W(W), .F(FRAC_BITS)) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dt_valid),
        .singular  (dt_singular),
        .dneg      (dt_neg),
        .dmag      (dt_mag),
        .cof       (dt_cof),
        .out_valid (res_valid),
        .res       (res),
        .flags     (flags)
    );

    assign out_ch.valid         = res_valid;
    assign out_ch.res_col0_row0 = res[0][0];
    assign out_ch.res_col0_row1 = res[1][0];
    assign out_ch.res_col0_row2 = res[2][0];
    assign out_ch.res_col1_row0 = res[0][1];
    assign out_ch.res_col1_row1 = res[1][1];
    assign out_ch.res_col1_row2 = res[2][1];
    assign out_ch.res_col2_row0 = res[0][2];
    assign out_ch.res_col2_row1 = res[1][2];
    assign out_ch.res_col2_row2 = res[2][2];
    assign out_ch.singular      = flags.singular;
    assign out_ch.saturated     = flags.saturated;

endmodule
